/* sv/mgsa_pkg.sv */
// mgsa_pkg: shared types and constants for the max-gap seat allocator
// used by max_gap_seat_allocator_unit; no dependencies
`default_nettype none
package mgsa_pkg;

	localparam int MAX_SEATS    = 1024;
	localparam int MAX_STUDENTS = 1024;
	localparam int SEAT_W       = 11;
	localparam int SEAT_AW      = $clog2(MAX_SEATS);
	localparam int STU_AW       = $clog2(MAX_STUDENTS);
	localparam int STU_DW       = SEAT_AW + 1;

	localparam logic ACT_ENTER = 1'b0;
	localparam logic ACT_LEAVE = 1'b1;

	localparam logic CFG_SEATS = 1'b0;
	localparam logic CFG_SAFE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_GAP  = 2'd1,
		ST_NOT_SAT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_WALL,
		S_DECIDE,
		S_LCHK
	} state_t;

	typedef struct packed {
		logic              action;
		logic [SEAT_W-1:0] student_id;
	} in_t;

	typedef struct packed {
		logic [SEAT_W-1:0] seat;
		logic [SEAT_W-1:0] min_distance;
		logic              min_infinite;
		logic              safe_ok;
		status_t           status;
	} out_t;

endpackage
`default_nettype wire

/* sv/mgsa_ram.sv */
// mgsa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module mgsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* sv/max_gap_seat_allocator_unit.sv */
// max_gap_seat_allocator_unit: top level of the max-gap seat allocator
// depends on mgsa_pkg and mgsa_ram
`default_nettype none
// After reset the block runs a clearing pass over the occupancy and student memories
// and takes no item until it ends; configuration writes are taken throughout. One
// item is handled at a time. An enter walks the occupancy memory one seat per cycle
// over the configured seats; a leave reads the student memory. The result sits in an
// output register, and the next item is accepted while it waits to be taken.
module max_gap_seat_allocator_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire mgsa_pkg::in_t             in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output mgsa_pkg::out_t                 out_data,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [mgsa_pkg::SEAT_W-1:0] cfg_wdata
);
	import mgsa_pkg::*;

	state_t state_q, state_d;

	logic [SEAT_W-1:0] seats_q, safe_q, n_eff, n_p1;
	logic [SEAT_W-1:0] id_q;
	logic              id_ok;

	logic [SEAT_W-1:0] cnt_q;
	logic              vld_s1;
	logic [SEAT_W-1:0] pos_s1;
	logic              issue;

	logic [SEAT_W-1:0] prev_q, best_l_q, best_r_q, best_len_q;
	logic              found_q;
	logic              gap_hit;
	logic [SEAT_W-1:0] gap_p, gap_len;

	logic [SEAT_W-1:0] min_q, min_n;
	logic              inf_q, inf_n;

	logic              occ_we, occ_wdata, occ_rdata;
	logic [SEAT_AW-1:0] occ_waddr, occ_raddr;
	logic              stu_we;
	logic [STU_AW-1:0] stu_waddr, stu_raddr;
	logic [STU_DW-1:0] stu_wdata, stu_rdata;

	logic              out_free, out_load, accept;
	logic [SEAT_W:0]   mid_sum;
	logic [SEAT_W-1:0] mid, d1, d2, leave_seat;
	logic              enter_ok, leave_ok;
	out_t              res;

	assign n_eff = (seats_q > SEAT_W'(MAX_SEATS)) ? SEAT_W'(MAX_SEATS) : seats_q;
	assign n_p1  = n_eff + SEAT_W'(1);
	assign id_ok = (id_q != '0) && (id_q <= SEAT_W'(MAX_STUDENTS));
	assign out_free = !out_valid || out_ready;
	assign accept = in_valid && in_ready;
	assign issue = (state_q == S_SCAN) && (cnt_q < n_eff);

	mgsa_ram #(.WIDTH(1), .DEPTH(MAX_SEATS)) u_occ (
		.clk  (clk),
		.we   (occ_we),
		.waddr(occ_waddr),
		.wdata(occ_wdata),
		.raddr(occ_raddr),
		.rdata(occ_rdata)
	);

	mgsa_ram #(.WIDTH(STU_DW), .DEPTH(MAX_STUDENTS)) u_stu (
		.clk  (clk),
		.we   (stu_we),
		.waddr(stu_waddr),
		.wdata(stu_wdata),
		.raddr(stu_raddr),
		.rdata(stu_rdata)
	);

	// gap evaluation
	assign gap_hit = (state_q == S_WALL) || ((state_q == S_SCAN) && vld_s1 && occ_rdata);
	assign gap_p   = (state_q == S_WALL) ? n_p1 : pos_s1;
	assign gap_len = (gap_p - prev_q) >> 1;

	// placement and running minimum
	assign mid_sum    = {1'b0, best_l_q} + {1'b0, best_r_q};
	assign mid        = mid_sum[SEAT_W:1];
	assign d1         = mid - best_l_q;
	assign d2         = best_r_q - mid;
	assign enter_ok   = id_ok && (best_len_q != '0);
	assign leave_ok   = id_ok && stu_rdata[STU_DW-1];
	assign leave_seat = {1'b0, stu_rdata[SEAT_AW-1:0]} + SEAT_W'(1);

	always_comb begin
		min_n = min_q;
		inf_n = inf_q;
		if ((state_q == S_DECIDE) && enter_ok) begin
			if (best_l_q != '0 && (inf_n || d1 < min_n)) begin
				min_n = d1;
				inf_n = 1'b0;
			end
			if (best_r_q != n_p1 && (inf_n || d2 < min_n)) begin
				min_n = d2;
				inf_n = 1'b0;
			end
		end
	end

	always_comb begin
		res.seat   = '0;
		res.status = ST_DONE;
		if (state_q == S_DECIDE) begin
			if (enter_ok) begin
				res.seat = mid;
			end else begin
				res.status = ST_NO_GAP;
			end
		end else begin
			if (leave_ok) begin
				res.seat = leave_seat;
			end else begin
				res.status = ST_NOT_SAT;
			end
		end
		res.min_distance = inf_n ? '0 : min_n;
		res.min_infinite = inf_n;
		res.safe_ok      = inf_n || (min_n >= safe_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (cnt_q == SEAT_W'(MAX_SEATS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = (in_data.action == ACT_ENTER) ? S_SCAN : S_LCHK;
				end
			end
			S_SCAN: begin
				if (!issue && !vld_s1) begin
					state_d = S_WALL;
				end
			end
			S_WALL: state_d = S_DECIDE;
			S_DECIDE, S_LCHK: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		in_ready  = 1'b0;
		out_load  = 1'b0;
		occ_we    = 1'b0;
		occ_waddr = mid[SEAT_AW-1:0] - SEAT_AW'(1);
		occ_wdata = 1'b1;
		occ_raddr = cnt_q[SEAT_AW-1:0];
		stu_we    = 1'b0;
		stu_waddr = STU_AW'(id_q - SEAT_W'(1));
		stu_wdata = {1'b1, occ_waddr};
		stu_raddr = STU_AW'(id_q - SEAT_W'(1));
		case (state_q)
			S_CLEAR: begin
				occ_we    = 1'b1;
				occ_waddr = cnt_q[SEAT_AW-1:0];
				occ_wdata = 1'b0;
				stu_we    = 1'b1;
				stu_waddr = STU_AW'(cnt_q);
				stu_wdata = '0;
			end
			S_IDLE: begin
				in_ready  = 1'b1;
				stu_raddr = STU_AW'(in_data.student_id - SEAT_W'(1));
			end
			S_DECIDE: begin
				out_load = out_free;
				occ_we   = out_free && enter_ok;
				stu_we   = out_free && enter_ok;
			end
			S_LCHK: begin
				out_load  = out_free;
				occ_we    = out_free && leave_ok;
				occ_waddr = stu_rdata[SEAT_AW-1:0];
				occ_wdata = 1'b0;
				stu_we    = out_free && leave_ok;
				stu_wdata = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			seats_q   <= SEAT_W'(MAX_SEATS);
			safe_q    <= '0;
			min_q     <= '0;
			inf_q     <= 1'b1;
			out_valid <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SEATS: seats_q <= cfg_wdata;
					CFG_SAFE:  safe_q  <= cfg_wdata;
					default: ;
				endcase
			end
			vld_s1 <= issue;
			if (state_q == S_CLEAR || issue) begin
				cnt_q <= cnt_q + SEAT_W'(1);
			end else if (state_q == S_IDLE) begin
				cnt_q <= '0;
			end
			if (accept) begin
				found_q <= 1'b0;
			end else if (gap_hit && (!found_q || gap_len > best_len_q)) begin
				found_q <= 1'b1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (state_q == S_DECIDE && out_free) begin
				min_q <= min_n;
				inf_q <= inf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= cnt_q + SEAT_W'(1);
		if (accept) begin
			id_q     <= in_data.student_id;
			prev_q   <= '0;
		end else if (gap_hit) begin
			prev_q <= gap_p;
			if (!found_q || gap_len > best_len_q) begin
				best_len_q <= gap_len;
				best_l_q   <= prev_q;
				best_r_q   <= gap_p;
			end
		end
		if (out_load) begin
			out_data <= res;
		end
	end

endmodule
`default_nettype wire
